FILE: hw/rtl/tdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg - trial division factoriser package
// Widths, microcode word layout, step labels and the microcode ROM.
// ----------------------------------------------------------------------------
package tdf_pkg;

    // Operand width
    localparam int unsigned WIDTH     = 32;
    localparam int unsigned CNT_W     = $clog2(WIDTH);
    localparam int unsigned PC_W      = 4;

    // Datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,        // take an input word, clear pending factor
        OP_DIV_START,   // start remaining / divisor
        OP_PUSH_DIV,    // divisor is a factor: remaining <= quotient
        OP_PUSH_REM,    // remaining itself is the final factor
        OP_STEP_DIV,    // next trial divisor
        OP_FLUSH,       // send pending factor marked last
        OP_EMPTY        // send the empty result
    } t_op;

    // Jump condition
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_REM_LE1,
        COND_DIV_BUSY,
        COND_Q_LT_D,
        COND_R_NZ
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // Step labels
    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHK    = 4'd1;
    localparam logic [PC_W-1:0] STEP_DSTART = 4'd2;
    localparam logic [PC_W-1:0] STEP_DWAIT  = 4'd3;
    localparam logic [PC_W-1:0] STEP_TEST   = 4'd4;
    localparam logic [PC_W-1:0] STEP_MOD    = 4'd5;
    localparam logic [PC_W-1:0] STEP_HIT    = 4'd6;
    localparam logic [PC_W-1:0] STEP_NEXT   = 4'd7;
    localparam logic [PC_W-1:0] STEP_TAIL   = 4'd8;
    localparam logic [PC_W-1:0] STEP_LASTF  = 4'd9;
    localparam logic [PC_W-1:0] STEP_FLUSH  = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMPTY  = 4'd11;

    // Microcode ROM: if the condition holds jump to target, else fall through
    function automatic t_ctrl f_ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:   w = '{op: OP_LOAD,      cond: COND_NONE,     target: STEP_IDLE};
            STEP_CHK:    w = '{op: OP_NOP,       cond: COND_REM_LE1,  target: STEP_EMPTY};
            STEP_DSTART: w = '{op: OP_DIV_START, cond: COND_NONE,     target: STEP_IDLE};
            STEP_DWAIT:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: STEP_DWAIT};
            STEP_TEST:   w = '{op: OP_NOP,       cond: COND_Q_LT_D,   target: STEP_TAIL};
            STEP_MOD:    w = '{op: OP_NOP,       cond: COND_R_NZ,     target: STEP_NEXT};
            STEP_HIT:    w = '{op: OP_PUSH_DIV,  cond: COND_ALWAYS,   target: STEP_DSTART};
            STEP_NEXT:   w = '{op: OP_STEP_DIV,  cond: COND_ALWAYS,   target: STEP_DSTART};
            STEP_TAIL:   w = '{op: OP_NOP,       cond: COND_REM_LE1,  target: STEP_FLUSH};
            STEP_LASTF:  w = '{op: OP_PUSH_REM,  cond: COND_NONE,     target: STEP_IDLE};
            STEP_FLUSH:  w = '{op: OP_FLUSH,     cond: COND_ALWAYS,   target: STEP_IDLE};
            STEP_EMPTY:  w = '{op: OP_EMPTY,     cond: COND_ALWAYS,   target: STEP_IDLE};
            default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/trial_division_factorizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_core - prime factoriser by trial division
// Microcoded sequencer over a shared restoring divider; emits the factors
// of each input word in ascending order, the final one marked with tlast.
// ----------------------------------------------------------------------------
// One input word is taken at a time and yields a run of output words, one per
// prime factor (repeats included), smallest first, tlast on the last one.
// Inputs 0 and 1 give a single word with factor 0, tlast and tuser set.
// Every trial divisor (2, then 3, 5, 7, ...) costs one pass of the bit-serial
// divider plus its test steps; divisors run up to the second-largest prime
// factor and on while divisor squared does not exceed the remaining value,
// so the time an input takes grows with the larger of its second-largest
// factor and the square root of its largest, and is longest for a 32-bit
// prime. A factor is held back one step so that tlast can be set; a stalled
// output only holds the sequencer when a further word has to be sent.
module trial_division_factorizer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [tdf_pkg::WIDTH-1:0]  i_s_tdata,   // [31:0] number
    // output stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [tdf_pkg::WIDTH-1:0]  o_m_tdata,   // [31:0] factor
    output logic                       o_m_tlast,
    output logic                       o_m_tuser    // [0] empty_res
);

    localparam int unsigned W = tdf_pkg::WIDTH;

    // Sequencer
    logic [tdf_pkg::PC_W-1:0] r_pc, n_pc;
    tdf_pkg::t_ctrl           cw;
    logic                     cond_hit;
    logic                     stall;
    logic                     out_free;

    // Working registers
    logic [W-1:0] r_rem;
    logic [W-1:0] r_div;
    logic [W-1:0] r_pend;
    logic         r_pend_valid;

    // Divider
    logic [W-1:0]              r_quo;
    logic [W-1:0]              r_part;
    logic [tdf_pkg::CNT_W-1:0] r_cnt;
    logic                      r_div_busy;
    logic [W:0]                shifted;
    logic [W:0]                diff;

    // Output register
    logic         r_m_valid;
    logic [W-1:0] r_m_data;
    logic         r_m_last;
    logic         r_m_empty;

    assign cw       = tdf_pkg::f_ucode(r_pc);
    assign out_free = !r_m_valid || i_m_tready;

    // Condition select
    always_comb begin
        case (cw.cond)
            tdf_pkg::COND_NONE:     cond_hit = 1'b0;
            tdf_pkg::COND_ALWAYS:   cond_hit = 1'b1;
            tdf_pkg::COND_REM_LE1:  cond_hit = (r_rem <= W'(1));
            tdf_pkg::COND_DIV_BUSY: cond_hit = r_div_busy;
            tdf_pkg::COND_Q_LT_D:   cond_hit = (r_quo < r_div);
            tdf_pkg::COND_R_NZ:     cond_hit = (r_part != '0);
            default:                cond_hit = 1'b0;
        endcase
    end

    // Hold the step while its word cannot move
    always_comb begin
        case (cw.op) inside
            tdf_pkg::OP_LOAD:     stall = !i_s_tvalid;
            tdf_pkg::OP_PUSH_DIV,
            tdf_pkg::OP_PUSH_REM: stall = r_pend_valid && !out_free;
            tdf_pkg::OP_FLUSH,
            tdf_pkg::OP_EMPTY:    stall = !out_free;
            default:              stall = 1'b0;
        endcase
    end

    assign o_s_tready = (cw.op == tdf_pkg::OP_LOAD);

    // Next step
    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (cond_hit) begin
            n_pc = cw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tdf_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Remaining value, trial divisor and pending factor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= '0;
            r_div        <= W'(2);
            r_pend_valid <= 1'b0;
        end else if (!stall) begin
            case (cw.op)
                tdf_pkg::OP_LOAD: begin
                    r_rem        <= i_s_tdata;
                    r_div        <= W'(2);
                    r_pend_valid <= 1'b0;
                end
                tdf_pkg::OP_PUSH_DIV: begin
                    r_rem        <= r_quo;
                    r_pend       <= r_div;
                    r_pend_valid <= 1'b1;
                end
                tdf_pkg::OP_PUSH_REM: begin
                    r_pend       <= r_rem;
                    r_pend_valid <= 1'b1;
                end
                tdf_pkg::OP_STEP_DIV: begin
                    r_div <= (r_div == W'(2)) ? W'(3) : r_div + W'(2);
                end
                tdf_pkg::OP_FLUSH: begin
                    r_pend_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Restoring divider, one quotient bit a cycle
    assign shifted = {r_part, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_cnt      <= '0;
        end else if (cw.op == tdf_pkg::OP_DIV_START) begin
            r_div_busy <= 1'b1;
            r_cnt      <= tdf_pkg::CNT_W'(W - 1);
            r_quo      <= r_rem;
            r_part     <= '0;
        end else if (r_div_busy) begin
            if (!diff[W]) begin
                r_part <= diff[W-1:0];
                r_quo  <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_part <= shifted[W-1:0];
                r_quo  <= {r_quo[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (!stall && (cw.op == tdf_pkg::OP_FLUSH)) begin
            r_m_valid <= 1'b1;
            r_m_data  <= r_pend;
            r_m_last  <= 1'b1;
            r_m_empty <= 1'b0;
        end else if (!stall && (cw.op == tdf_pkg::OP_EMPTY)) begin
            r_m_valid <= 1'b1;
            r_m_data  <= '0;
            r_m_last  <= 1'b1;
            r_m_empty <= 1'b1;
        end else if (!stall && r_pend_valid &&
                     ((cw.op == tdf_pkg::OP_PUSH_DIV) || (cw.op == tdf_pkg::OP_PUSH_REM))) begin
            r_m_valid <= 1'b1;
            r_m_data  <= r_pend;
            r_m_last  <= 1'b0;
            r_m_empty <= 1'b0;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_empty;

`ifndef SYNTH
    // Empty result is always the only, hence last, word of its run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_empty) |-> r_m_last)
        else $error("empty result without tlast");

    // Final word of a run needs a held factor
    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.op == tdf_pkg::OP_FLUSH) |-> r_pend_valid)
        else $error("flush with no pending factor");

    // Divider never restarted mid-division
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cw.op == tdf_pkg::OP_DIV_START) |-> !r_div_busy)
        else $error("divider started while busy");

    // A trial divisor below two would stall or corrupt the division
    a_div_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div >= W'(2))
        else $error("trial divisor below two");
`endif

endmodule

FILE: tb/trial_division_factorizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_checker - scoreboard for the factoriser core
// Watches both stream channels. Every number taken on the input side is
// factorised here by trial division. The resulting factor words are queued,
// and each word leaving the core is compared with the oldest one queued.
// ----------------------------------------------------------------------------
module trial_division_factorizer_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel of the core
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [tdf_pkg::WIDTH-1:0]  i_s_tdata,   // [31:0] number
    // output channel of the core
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [tdf_pkg::WIDTH-1:0]  i_m_tdata,   // [31:0] factor
    input  logic                       i_m_tlast,
    input  logic                       i_m_tuser,   // [0] empty_res
    // status for the testbench top
    output int unsigned                o_error_count,
    output int unsigned                o_pending,
    output int unsigned                o_numbers_seen,
    output int unsigned                o_factors_seen,
    output int unsigned                o_empty_seen
);

    localparam int unsigned W           = tdf_pkg::WIDTH;
    localparam int unsigned MAX_FACTORS = 32;

    typedef struct {
        logic [W-1:0] factor;
        logic         last;
        logic         empty;
    } t_factor_word;

    t_factor_word expected_factors [$];

    // One line per fault, and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        o_error_count++;
    endtask

    // Append one expected word at the tail of the queue
    function automatic void add_expected(input t_factor_word w);
        expected_factors.insert(expected_factors.size(), w);
    endfunction

    // Take the oldest expected word off the queue
    function automatic t_factor_word take_expected();
        t_factor_word w;
        w = expected_factors[0];
        expected_factors.delete(0);
        return w;
    endfunction

    // Factorise one number and queue the words it should produce
    function automatic void predict_factors(input logic [W-1:0] number);
        t_factor_word w;
        logic [W-1:0] rem;
        logic [W-1:0] div;
        int unsigned  n;

        rem     = number;
        n       = 0;
        w.last  = 1'b0;
        w.empty = 1'b0;

        if (rem <= 1) begin
            w.factor = '0;
            w.last   = 1'b1;
            w.empty  = 1'b1;
            add_expected(w);
            n = 1;
        end else begin
            // twos first
            while (rem[0] == 1'b0 && n < MAX_FACTORS) begin
                w.factor = W'(2);
                add_expected(w);
                n++;
                rem = rem >> 1;
            end
            // odd divisors while div squared fits under rem
            div = W'(3);
            while (n < MAX_FACTORS && div <= rem / div) begin
                if (rem % div == 0) begin
                    w.factor = div;
                    add_expected(w);
                    n++;
                    rem = rem / div;
                end else begin
                    div = div + W'(2);
                end
            end
            // leftover is itself prime
            if (rem > 1 && n < MAX_FACTORS) begin
                w.factor = rem;
                add_expected(w);
                n++;
            end
            expected_factors[expected_factors.size() - 1].last = 1'b1;
        end

        o_pending += n;
    endfunction

    // Compare one output word with the oldest expectation
    task automatic check_factor_word();
        t_factor_word exp_w;
        if (expected_factors.size() == 0) begin
            report_mismatch($sformatf("unexpected word factor=%0d last=%0b empty=%0b",
                                      i_m_tdata, i_m_tlast, i_m_tuser));
            return;
        end
        exp_w = take_expected();
        o_pending--;
        o_factors_seen++;
        if (exp_w.empty)
            o_empty_seen++;
        if (i_m_tdata !== exp_w.factor)
            report_mismatch($sformatf("factor %0d, expected %0d", i_m_tdata, exp_w.factor));
        if (i_m_tlast !== exp_w.last)
            report_mismatch($sformatf("tlast %0b, expected %0b (factor %0d)",
                                      i_m_tlast, exp_w.last, exp_w.factor));
        if (i_m_tuser !== exp_w.empty)
            report_mismatch($sformatf("empty flag %0b, expected %0b (factor %0d)",
                                      i_m_tuser, exp_w.empty, exp_w.factor));
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                predict_factors(i_s_tdata);
                o_numbers_seen++;
            end
            if (i_m_tvalid && i_m_tready)
                check_factor_word();
        end
    end

endmodule

FILE: tb/tb_trial_division_factorizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer_core - testbench for the factoriser core
// Sends a directed set of numbers (zero, one, powers of two, all ones, squares,
// primes), then random numbers that are mostly products of small primes, with
// bursty input, a randomly stalled output and one long output hold-off. The
// checker alongside predicts and compares every factor word.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer_core;

    localparam int unsigned W         = tdf_pkg::WIDTH;
    localparam int unsigned N_RANDOM  = 80;
    localparam int unsigned HOLD_LEN  = 400;
    localparam int unsigned TAIL_WAIT = 100;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [W-1:0]  s_tdata;     // [31:0] number
    logic          m_tvalid;
    logic          m_tready;
    logic [W-1:0]  m_tdata;     // [31:0] factor
    logic          m_tlast;
    logic          m_tuser;     // [0] empty_res

    int unsigned   error_count;
    int unsigned   pending;
    int unsigned   numbers_seen;
    int unsigned   factors_seen;
    int unsigned   empty_seen;

    // stimulus state, and the flags it hands to the receiver
    bit            tx_gaps_on;
    bit            rx_stall_on;
    bit            hold_req;
    int unsigned   burst_left;

    int unsigned small_primes [0:30] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                         43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97,
                                         101, 103, 107, 109, 113, 127};

    logic [W-1:0] directed_numbers [$] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4,
        32'h8000_0000,              // longest run of twos
        32'hC000_0000,              // three times a long run of twos
        32'hFFFF_FFFF,              // all ones: 3*5*17*257*65537
        32'hFFFF_0000,
        32'hAAAA_AAAA, 32'h5555_5555,
        32'd9, 32'd25, 32'd49,      // divisor squared equals remainder
        32'd15, 32'd97,
        32'd131074,                 // 2 * 65537, large prime left over
        32'd4294836225,             // 65535 squared
        32'd1000003,
        32'd16777213                // prime near 2^24, long search
    };

    trial_division_factorizer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    trial_division_factorizer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .i_m_tuser      (m_tuser),
        .o_error_count  (error_count),
        .o_pending      (pending),
        .o_numbers_seen (numbers_seen),
        .o_factors_seen (factors_seen),
        .o_empty_seen   (empty_seen)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: ready and stall runs of random length, or one long hold-off
    initial begin
        int unsigned hold_left;
        int unsigned run_left;
        bit          run_ready;
        hold_left = 0;
        run_left  = 0;
        run_ready = 1'b1;
        m_tready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!rx_stall_on) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = ($urandom_range(0, 2) != 0);
                    run_left  = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
                end
                m_tready <= run_ready;
                run_left--;
            end
        end
    end

    // Offer one number and wait for it to be taken; called at a falling edge
    task automatic send_number(input logic [W-1:0] number);
        int unsigned gap;
        if (tx_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Mostly numbers with small factors so the search stays short
    function automatic logic [W-1:0] random_number(input bit many_factors);
        logic [63:0] acc;
        int unsigned p;
        int unsigned n;
        acc = 64'd1;
        if (many_factors)
            return (32'(1) << $urandom_range(20, 31)) * small_primes[$urandom_range(0, 2)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 14);
                repeat (n) begin
                    p = small_primes[$urandom_range(0, 30)];
                    if (acc * p <= 64'hFFFF_FFFF)
                        acc = acc * p;
                end
            end
            4, 5:    acc = 64'({$urandom_range(0, 4095)} | 1) << $urandom_range(0, 20);
            6:       acc = 64'($urandom_range(0, 65535));
            7:       acc = 64'($urandom_range(0, (1 << 20) - 1));
            8:       acc = 64'($urandom_range(0, 2));
            default: begin
                p   = small_primes[$urandom_range(1, 30)];
                acc = 64'(p * p) << $urandom_range(0, 16);
            end
        endcase
        return acc[W-1:0];
    endfunction

    // Stimulus and verdict
    initial begin
        int unsigned i;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        i_rst_n     = 1'b0;
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        hold_req    = 1'b0;
        burst_left  = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_numbers[k])
            send_number(directed_numbers[k]);

        for (i = 0; i < N_RANDOM; i++) begin
            // flat-out stretch with no idling on either side
            if (i == 30) begin
                tx_gaps_on  = 1'b0;
                rx_stall_on = 1'b0;
            end
            if (i == 45) begin
                tx_gaps_on  = 1'b1;
                rx_stall_on = 1'b1;
            end
            // long output hold-off while long factor runs keep coming
            if (i == 60)
                hold_req = 1'b1;
            send_number(random_number(i >= 60 && i < 66));
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray words
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_WAIT) @(negedge i_clk);

        $display("Covered %0d numbers (zero/one, powers of two, all ones, squares, primes,",
                 numbers_seen);
        $display("random products) giving %0d factor words, %0d empty, under stalls and hold-off",
                 factors_seen, empty_seen);
        if (error_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
